// File: sv/fdtd1d_pkg.sv
// Shared types, widths and codes of the 1-D Yee field step block.
`default_nettype none

package fdtd1d_pkg;

	// grid size default
	localparam int CELLS_DEFAULT = 256;

	// payload widths
	localparam int OP_W    = 2;
	localparam int IDX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int FIELD_W = 18;
	localparam int SRC_W   = 8;

	// arithmetic widths: difference, product, rounded product, field sum
	localparam int DIFF_W = FIELD_W + 1;
	localparam int PROD_W = COEF_W + 1 + DIFF_W;
	localparam int FRAC_W = 15;
	localparam int RND_W  = PROD_W - FRAC_W;
	localparam int SUM_W  = RND_W + 1;

	localparam logic signed [FIELD_W-1:0] FIELD_MAX = 18'sh1FFFF;
	localparam logic signed [FIELD_W-1:0] FIELD_MIN = 18'sh20000;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

	// item op codes
	localparam logic [OP_W-1:0] OP_LOAD_E = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_H = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP   = 2'd2;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_W   = PADDR_W - 2;
	localparam logic [REG_W-1:0] REG_SOURCE_CELL = 1'd0;
	localparam logic [SRC_W-1:0] SOURCE_CELL_RESET = 8'd1;

	// cycles between the last write-back issue and the next dependent read
	localparam int DRAIN_W = 2;
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_H_PASS,
		ST_H_WAIT,
		ST_H_INJ,
		ST_HI_WAIT,
		ST_E_PASS,
		ST_E_WAIT,
		ST_E_INJ,
		ST_EI_WAIT,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_H_PASS,
		PH_H_INJ,
		PH_E_PASS,
		PH_E_INJ
	} phase_t;

	// one update slot travelling down the pipeline
	typedef struct packed {
		logic   vld;
		phase_t ph;
		logic   lo;
		logic   hi;
	} issue_t;

	// sequencer status toward the datapath
	typedef struct packed {
		logic   idle;
		logic   clr;
		logic   done;
		issue_t iss;
	} seq_ctl_t;

endpackage

`default_nettype wire

// File: sv/fdtd1d_if.sv
// Valid/ready channels for input items and result words.
`default_nettype none

interface fdtd1d_item_if;
	logic                                      valid;
	logic                                      ready;
	logic [fdtd1d_pkg::OP_W-1:0]               op;
	logic [fdtd1d_pkg::IDX_W-1:0]              cell_index;
	logic [fdtd1d_pkg::COEF_W-1:0]             coef_value;
	logic signed [fdtd1d_pkg::FIELD_W-1:0]     e_source;
	logic signed [fdtd1d_pkg::FIELD_W-1:0]     h_source;

	modport source (output valid, op, cell_index, coef_value, e_source, h_source,
		input ready);
	modport sink (input valid, op, cell_index, coef_value, e_source, h_source,
		output ready);
endinterface

interface fdtd1d_result_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [fdtd1d_pkg::FIELD_W-1:0]     e_first;
	logic signed [fdtd1d_pkg::FIELD_W-1:0]     e_last;
	logic                                      saturated;

	modport source (output valid, e_first, e_last, saturated, input ready);
	modport sink (input valid, e_first, e_last, saturated, output ready);
endinterface

`default_nettype wire

// File: sv/fdtd1d_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module fdtd1d_ram #(
	parameter int DEPTH = fdtd1d_pkg::CELLS_DEFAULT,
	parameter int WIDTH = fdtd1d_pkg::FIELD_W
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/fdtd1d_upd.sv
// Shared field update unit: difference, multiply, round, add and saturate.
`default_nettype none

module fdtd1d_upd #(
	parameter int AW = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire fdtd1d_pkg::issue_t                     in_tag,
	input  wire logic [AW-1:0]                          in_idx,
	input  wire logic signed [fdtd1d_pkg::FIELD_W-1:0]  field,
	input  wire logic [fdtd1d_pkg::COEF_W-1:0]          coef,
	input  wire logic signed [fdtd1d_pkg::FIELD_W-1:0]  opa,
	input  wire logic signed [fdtd1d_pkg::FIELD_W-1:0]  opb,
	output fdtd1d_pkg::issue_t                          wr_tag,
	output logic [AW-1:0]                               wr_idx,
	output logic signed [fdtd1d_pkg::FIELD_W-1:0]       wr_val,
	output logic                                        wr_clip
);

	localparam int FW = fdtd1d_pkg::FIELD_W;
	localparam int DW = fdtd1d_pkg::DIFF_W;
	localparam int PW = fdtd1d_pkg::PROD_W;
	localparam int RW = fdtd1d_pkg::RND_W;
	localparam int SW = fdtd1d_pkg::SUM_W;

	logic signed [DW-1:0] diff;

	logic                          vld_s2, vld_s3, vld_s4;
	fdtd1d_pkg::issue_t            tag_s2, tag_s3, tag_s4;
	logic [AW-1:0]                 idx_s2, idx_s3, idx_s4;
	logic signed [FW-1:0]          field_s2, field_s3, field_s4;
	logic [fdtd1d_pkg::COEF_W-1:0] coef_s2;
	logic signed [DW-1:0]          diff_s2;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          prod_s3;
	logic signed [PW-1:0]          prod_rnd;
	logic signed [RW-1:0]          rnd_s4;
	logic signed [SW-1:0]          sum;
	logic                          ovf;

	// exact difference of two fields
	assign diff = DW'(opa) - DW'(opb);

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= in_tag.vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 2 operands
	always_ff @(posedge clk) begin
		tag_s2   <= in_tag;
		idx_s2   <= in_idx;
		field_s2 <= field;
		coef_s2  <= coef;
		diff_s2  <= diff;
	end

	// coefficient times difference, unsigned Q1.15 against signed field
	assign prod = $signed({1'b0, coef_s2}) * diff_s2;

	always_ff @(posedge clk) begin
		tag_s3   <= tag_s2;
		idx_s3   <= idx_s2;
		field_s3 <= field_s2;
		prod_s3  <= prod;
	end

	// round to nearest, halves upward: floor((p + 2^14) / 2^15)
	assign prod_rnd = prod_s3 + fdtd1d_pkg::ROUND_HALF;

	always_ff @(posedge clk) begin
		tag_s4   <= tag_s3;
		idx_s4   <= idx_s3;
		field_s4 <= field_s3;
		rnd_s4   <= prod_rnd[PW-1:fdtd1d_pkg::FRAC_W];
	end

	// add to the field and clip to Q3.14
	assign sum = SW'(field_s4) + SW'(rnd_s4);
	assign ovf = (sum[SW-1:FW-1] != '0) && (sum[SW-1:FW-1] != '1);

	always_comb begin
		wr_tag     = tag_s4;
		wr_tag.vld = vld_s4;
		wr_idx     = idx_s4;
		wr_clip    = vld_s4 && ovf;
		if (!ovf) begin
			wr_val = sum[FW-1:0];
		end else if (sum[SW-1]) begin
			wr_val = fdtd1d_pkg::FIELD_MIN;
		end else begin
			wr_val = fdtd1d_pkg::FIELD_MAX;
		end
	end

endmodule

`default_nettype wire

// File: sv/fdtd1d_seq.sv
// Step sequencer: clearing sweep, H and E passes, source slots and drains.
`default_nettype none

module fdtd1d_seq #(
	parameter int CELLS = fdtd1d_pkg::CELLS_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     inject,
	input  wire logic [$clog2(CELLS)-1:0] src_idx,
	input  wire logic                     out_free,
	output fdtd1d_pkg::seq_ctl_t          ctl,
	output logic [$clog2(CELLS)-1:0]      idx
);

	localparam int AW = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

	fdtd1d_pkg::seq_state_t state_q, state_d;
	logic [AW-1:0]                      idx_q;
	logic [fdtd1d_pkg::DRAIN_W-1:0]     drn_q;
	logic                               drained;

	assign drained = (drn_q == fdtd1d_pkg::DRAIN_LAST);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fdtd1d_pkg::ST_CLEAR: begin
				if (idx_q == LAST_IDX) state_d = fdtd1d_pkg::ST_IDLE;
			end
			fdtd1d_pkg::ST_IDLE: begin
				if (start) state_d = fdtd1d_pkg::ST_H_PASS;
			end
			fdtd1d_pkg::ST_H_PASS: begin
				if (idx_q == '0) state_d = fdtd1d_pkg::ST_H_WAIT;
			end
			fdtd1d_pkg::ST_H_WAIT: begin
				if (drained) begin
					state_d = inject ? fdtd1d_pkg::ST_H_INJ : fdtd1d_pkg::ST_E_PASS;
				end
			end
			fdtd1d_pkg::ST_H_INJ: begin
				state_d = fdtd1d_pkg::ST_HI_WAIT;
			end
			fdtd1d_pkg::ST_HI_WAIT: begin
				if (drained) state_d = fdtd1d_pkg::ST_E_PASS;
			end
			fdtd1d_pkg::ST_E_PASS: begin
				if (idx_q == LAST_IDX) state_d = fdtd1d_pkg::ST_E_WAIT;
			end
			fdtd1d_pkg::ST_E_WAIT: begin
				if (drained) begin
					state_d = inject ? fdtd1d_pkg::ST_E_INJ : fdtd1d_pkg::ST_DONE;
				end
			end
			fdtd1d_pkg::ST_E_INJ: begin
				state_d = fdtd1d_pkg::ST_EI_WAIT;
			end
			fdtd1d_pkg::ST_EI_WAIT: begin
				if (drained) state_d = fdtd1d_pkg::ST_DONE;
			end
			fdtd1d_pkg::ST_DONE: begin
				if (out_free) state_d = fdtd1d_pkg::ST_IDLE;
			end
			default: state_d = fdtd1d_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdtd1d_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// cell counter: up for clear and E, down for H
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (state_q)
				fdtd1d_pkg::ST_CLEAR:  idx_q <= idx_q + 1'b1;
				fdtd1d_pkg::ST_IDLE:   idx_q <= LAST_IDX;
				fdtd1d_pkg::ST_H_PASS: idx_q <= idx_q - 1'b1;
				fdtd1d_pkg::ST_H_WAIT,
				fdtd1d_pkg::ST_HI_WAIT: idx_q <= '0;
				fdtd1d_pkg::ST_E_PASS: idx_q <= idx_q + 1'b1;
				default:               idx_q <= idx_q;
			endcase
		end
	end

	// count drain cycles in the wait states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drn_q <= '0;
		end else if (state_q == fdtd1d_pkg::ST_H_WAIT || state_q == fdtd1d_pkg::ST_HI_WAIT ||
				state_q == fdtd1d_pkg::ST_E_WAIT || state_q == fdtd1d_pkg::ST_EI_WAIT) begin
			drn_q <= drn_q + 1'b1;
		end else begin
			drn_q <= '0;
		end
	end

	// outputs
	always_comb begin
		ctl        = '0;
		idx        = idx_q;
		ctl.idle   = (state_q == fdtd1d_pkg::ST_IDLE);
		ctl.clr    = (state_q == fdtd1d_pkg::ST_CLEAR);
		ctl.done   = (state_q == fdtd1d_pkg::ST_DONE);
		ctl.iss.ph = fdtd1d_pkg::PH_H_PASS;
		unique case (state_q)
			fdtd1d_pkg::ST_H_PASS: begin
				ctl.iss.vld = 1'b1;
				ctl.iss.ph  = fdtd1d_pkg::PH_H_PASS;
			end
			fdtd1d_pkg::ST_H_INJ: begin
				ctl.iss.vld = 1'b1;
				ctl.iss.ph  = fdtd1d_pkg::PH_H_INJ;
				idx         = src_idx - 1'b1;
			end
			fdtd1d_pkg::ST_E_PASS: begin
				ctl.iss.vld = 1'b1;
				ctl.iss.ph  = fdtd1d_pkg::PH_E_PASS;
			end
			fdtd1d_pkg::ST_E_INJ: begin
				ctl.iss.vld = 1'b1;
				ctl.iss.ph  = fdtd1d_pkg::PH_E_INJ;
				idx         = src_idx;
			end
			default: begin
				ctl.iss.vld = 1'b0;
			end
		endcase
		ctl.iss.lo = (idx == '0);
		ctl.iss.hi = (idx == LAST_IDX);
	end

endmodule

`default_nettype wire

// File: sv/fdtd_1d_yee_field_step.sv
// Top level of the 1-D Yee field step: channels, config port, field stores.
//
// One-dimensional Yee FDTD step in signed Q3.14 with a total-field/scattered-
// field source. Coefficient loads (op 0 for E, op 1 for H) and unknown ops
// return the edge fields right away. A time step (op 2) runs the grid through
// one shared update pipeline at one cell per cycle: an H pass from the last
// cell down, an E pass from cell zero up, each followed by a drain, plus a
// source slot and a drain for each injection when source_cell is nonzero and
// lies inside the grid. After reset the block sweeps zeros through both field
// RAMs and accepts no word until done; source_cell writes are taken anytime.
// Input is accepted only while idle, and a result word waits in an output
// register until taken.
`default_nettype none

module fdtd_1d_yee_field_step #(
	parameter int CELLS = fdtd1d_pkg::CELLS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	fdtd1d_item_if.sink                            item,
	fdtd1d_result_if.source                        result,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fdtd1d_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [fdtd1d_pkg::PDATA_W-1:0]    pwdata,
	output logic      [fdtd1d_pkg::PDATA_W-1:0]    prdata,
	output logic                                   pready
);

	localparam int AW = $clog2(CELLS);
	localparam int FW = fdtd1d_pkg::FIELD_W;
	localparam int CW = fdtd1d_pkg::COEF_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

	logic [fdtd1d_pkg::SRC_W-1:0] source_cell_q;
	logic                         cfg_wr;
	logic                         reg_hit;

	fdtd1d_pkg::seq_ctl_t ctl;
	logic [AW-1:0]        iss_idx;
	logic                 in_acc, step_go, out_free, inject, load_ok;
	logic [AW-1:0]        src_idx;

	logic signed [FW-1:0] esrc_q, hsrc_q;
	fdtd1d_pkg::issue_t   iss_s1;
	logic [AW-1:0]        idx_s1;

	logic signed [FW-1:0] e_rd, h_rd;
	logic [CW-1:0]        ec_rd, hc_rd;
	logic                 e_we, h_we, ec_we, hc_we;
	logic [AW-1:0]        e_wa, h_wa;
	logic signed [FW-1:0] e_wd, h_wd;

	logic signed [FW-1:0] e_prev_q, h_prev_q;
	logic signed [FW-1:0] eh0_q, eh1_q, hh0_q, hh1_q;

	logic signed [FW-1:0] op_field, op_a, op_b;
	logic [CW-1:0]        op_coef;

	fdtd1d_pkg::issue_t   wr_tag;
	logic [AW-1:0]        wr_idx;
	logic signed [FW-1:0] wr_val;
	logic                 wr_clip, wr_is_h, wr_is_e;

	logic signed [FW-1:0] e_first_q, e_last_q;
	logic                 sat_q;
	logic                 out_valid_q;
	logic signed [FW-1:0] out_first_q, out_last_q;
	logic                 out_sat_q;

	// config port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[fdtd1d_pkg::PADDR_W-1:2] == fdtd1d_pkg::REG_SOURCE_CELL);
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? fdtd1d_pkg::PDATA_W'(source_cell_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_cell_q <= fdtd1d_pkg::SOURCE_CELL_RESET;
		end else if (cfg_wr) begin
			source_cell_q <= pwdata[fdtd1d_pkg::SRC_W-1:0];
		end
	end

	// item handshake and decode
	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = ctl.idle && out_free;
	assign in_acc     = item.valid && item.ready;
	assign step_go    = in_acc && (item.op == fdtd1d_pkg::OP_STEP);
	assign load_ok    = (32'(item.cell_index) < 32'(CELLS));
	assign ec_we      = in_acc && (item.op == fdtd1d_pkg::OP_LOAD_E) && load_ok;
	assign hc_we      = in_acc && (item.op == fdtd1d_pkg::OP_LOAD_H) && load_ok;
	assign inject     = (source_cell_q != '0) && (32'(source_cell_q) < 32'(CELLS));
	assign src_idx    = AW'(source_cell_q);

	// hold the source samples for the step
	always_ff @(posedge clk) begin
		if (step_go) begin
			esrc_q <= item.e_source;
			hsrc_q <= item.h_source;
		end
	end

	fdtd1d_seq #(
		.CELLS(CELLS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (step_go),
		.inject   (inject),
		.src_idx  (src_idx),
		.out_free (out_free),
		.ctl      (ctl),
		.idx      (iss_idx)
	);

	// field and coefficient stores
	fdtd1d_ram #(.DEPTH(CELLS), .WIDTH(FW)) u_e_fld (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(iss_idx), .rdata(e_rd)
	);
	fdtd1d_ram #(.DEPTH(CELLS), .WIDTH(FW)) u_h_fld (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(iss_idx), .rdata(h_rd)
	);
	fdtd1d_ram #(.DEPTH(CELLS), .WIDTH(CW)) u_e_cf (
		.clk(clk), .we(ec_we), .waddr(AW'(item.cell_index)), .wdata(item.coef_value),
		.raddr(iss_idx), .rdata(ec_rd)
	);
	fdtd1d_ram #(.DEPTH(CELLS), .WIDTH(CW)) u_h_cf (
		.clk(clk), .we(hc_we), .waddr(AW'(item.cell_index)), .wdata(item.coef_value),
		.raddr(iss_idx), .rdata(hc_rd)
	);

	// align the issue slot with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
		end else begin
			iss_s1 <= ctl.iss;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_idx;
	end

	// pick operands for the update unit
	always_comb begin
		op_field = h_rd;
		op_coef  = hc_rd;
		op_a     = '0;
		op_b     = '0;
		case (iss_s1.ph)
			fdtd1d_pkg::PH_H_PASS: begin
				op_a = iss_s1.hi ? eh1_q : e_prev_q;
				op_b = e_rd;
			end
			fdtd1d_pkg::PH_H_INJ: begin
				op_b = esrc_q;
			end
			fdtd1d_pkg::PH_E_PASS: begin
				op_field = e_rd;
				op_coef  = ec_rd;
				op_a     = h_rd;
				op_b     = iss_s1.lo ? hh1_q : h_prev_q;
			end
			fdtd1d_pkg::PH_E_INJ: begin
				op_field = e_rd;
				op_coef  = ec_rd;
				op_b     = hsrc_q;
			end
			default: begin
				op_field = h_rd;
			end
		endcase
	end

	// keep the neighbor of the previous cell
	always_ff @(posedge clk) begin
		if (iss_s1.vld && iss_s1.ph == fdtd1d_pkg::PH_H_PASS) begin
			e_prev_q <= e_rd;
		end
		if (iss_s1.vld && iss_s1.ph == fdtd1d_pkg::PH_E_PASS) begin
			h_prev_q <= h_rd;
		end
	end

	// shift the edge histories as the H pass reads the edge cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eh0_q <= '0;
			eh1_q <= '0;
			hh0_q <= '0;
			hh1_q <= '0;
		end else if (iss_s1.vld && iss_s1.ph == fdtd1d_pkg::PH_H_PASS) begin
			if (iss_s1.hi) begin
				eh1_q <= eh0_q;
				eh0_q <= e_rd;
			end
			if (iss_s1.lo) begin
				hh1_q <= hh0_q;
				hh0_q <= h_rd;
			end
		end
	end

	fdtd1d_upd #(
		.AW(AW)
	) u_upd (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_tag  (iss_s1),
		.in_idx  (idx_s1),
		.field   (op_field),
		.coef    (op_coef),
		.opa     (op_a),
		.opb     (op_b),
		.wr_tag  (wr_tag),
		.wr_idx  (wr_idx),
		.wr_val  (wr_val),
		.wr_clip (wr_clip)
	);

	// write back, or sweep zeros after reset
	assign wr_is_h = wr_tag.vld &&
		(wr_tag.ph == fdtd1d_pkg::PH_H_PASS || wr_tag.ph == fdtd1d_pkg::PH_H_INJ);
	assign wr_is_e = wr_tag.vld &&
		(wr_tag.ph == fdtd1d_pkg::PH_E_PASS || wr_tag.ph == fdtd1d_pkg::PH_E_INJ);
	assign e_we = ctl.clr || wr_is_e;
	assign h_we = ctl.clr || wr_is_h;
	assign e_wa = ctl.clr ? iss_idx : wr_idx;
	assign h_wa = ctl.clr ? iss_idx : wr_idx;
	assign e_wd = ctl.clr ? '0 : wr_val;
	assign h_wd = ctl.clr ? '0 : wr_val;

	// mirror the edge E cells and track clipping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_first_q <= '0;
			e_last_q  <= '0;
			sat_q     <= 1'b0;
		end else begin
			if (wr_is_e && wr_idx == '0) e_first_q <= wr_val;
			if (wr_is_e && wr_idx == LAST_IDX) e_last_q <= wr_val;
			if (step_go) begin
				sat_q <= 1'b0;
			end else if (wr_clip) begin
				sat_q <= 1'b1;
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && !step_go) || (ctl.done && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !step_go) begin
			out_first_q <= e_first_q;
			out_last_q  <= e_last_q;
			out_sat_q   <= 1'b0;
		end else if (ctl.done && out_free) begin
			out_first_q <= e_first_q;
			out_last_q  <= e_last_q;
			out_sat_q   <= sat_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.e_first   = out_first_q;
	assign result.e_last    = out_last_q;
	assign result.saturated = out_sat_q;

endmodule

`default_nettype wire
